/* design/eacm_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the attitude
// circular mean unit. Used by all modules but eacm_isqrt; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package eacm_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int ANGLE_BITS_DEF  = 16;

  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam logic [31:0] CORDIC_GAIN_INV = 32'd652032874;

  localparam logic [1:0] SEL_PHI   = 2'd0;
  localparam logic [1:0] SEL_THETA = 2'd1;
  localparam logic [1:0] SEL_PSI   = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       drop;
    logic       rot_start;
    logic       vec_start;
    logic [1:0] sel;
    logic       mul;
    logic       accum;
    logic       sq;
    logic       sqrt_start;
    logic       out_load;
  } eacm_cmd_t;

  typedef struct packed {
    logic at_bound;
    logic last;
    logic cordic_busy;
    logic sqrt_busy;
    logic out_busy;
  } eacm_sts_t;

  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* design/eacm_cordic.sv */
// Shared iterative CORDIC, one micro-rotation per cycle, in rotation or
// vectoring mode. Depends on eacm_pkg for the step count and arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module eacm_cordic #(
  parameter int CW = 44
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 vec_mode,
  input  wire logic signed [CW-1:0] x0,
  input  wire logic signed [CW-1:0] y0,
  input  wire logic        [32:0]   z0,
  output logic                      busy,
  output logic                      done,
  output logic signed [CW-1:0]      x,
  output logic signed [CW-1:0]      y,
  output logic        [31:0]        z
);
  import eacm_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  logic signed [CW-1:0] x_r, y_r;
  logic        [32:0]   z_r;
  logic [STEP_W-1:0]    step_r;
  logic                 busy_r, done_r, vec_r;

  logic signed [CW-1:0] xs, ys;
  logic        [32:0]   at;
  logic                 plus;

  always_comb begin
    xs   = x_r >>> step_r;
    ys   = y_r >>> step_r;
    at   = {1'b0, atan_turn(step_r)};
    plus = vec_r ? !(!y_r[CW-1] && (y_r != '0)) : !z_r[32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
      vec_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        vec_r  <= vec_mode;
      end else if (busy_r) begin
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= x0;
      y_r <= y0;
      z_r <= z0;
    end else if (busy_r) begin
      if (plus) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r[31:0];

endmodule

`default_nettype wire

/* design/eacm_isqrt.sv */
// Iterative floor integer square root, one result bit per cycle.
// Depends on nothing outside this file.
`timescale 1ns / 1ps
`default_nettype none

module eacm_isqrt #(
  parameter int W = 29
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [2*W-1:0] radicand,
  output logic                busy,
  output logic [W-1:0]        root
);
  localparam int SQ_W = 2 * W;
  localparam logic [SQ_W-1:0] TOP_BIT = SQ_W'(1) << (SQ_W - 2);

  logic [SQ_W-1:0] v_r, res_r, bit_r, trial;
  logic            busy_r;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (bit_r == SQ_W'(1))) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      res_r <= '0;
      bit_r <= TOP_BIT;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = res_r[W-1:0];

endmodule

`default_nettype wire

/* design/eacm_datapath.sv */
// Datapath: input and sine/cosine registers, running sums, sample counter,
// output register, with the shared CORDIC and the square root unit.
// Depends on eacm_pkg, eacm_cordic and eacm_isqrt.
`timescale 1ns / 1ps
`default_nettype none

module eacm_datapath #(
  parameter int MAX_SAMPLES = eacm_pkg::MAX_SAMPLES_DEF,
  parameter int ANGLE_BITS  = eacm_pkg::ANGLE_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [15:0]        in_phi,
  input  wire logic [15:0]        in_theta,
  input  wire logic [15:0]        in_psi,
  input  wire logic               in_last,
  input  wire eacm_pkg::eacm_cmd_t cmd,
  output eacm_pkg::eacm_sts_t     sts,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [63:0]             out_tdata,
  output logic [1:0]              out_tuser
);
  import eacm_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = CNT_W + 16;
  localparam int VW    = SUM_W + 1;
  localparam int CW    = SUM_W + 15;
  localparam int AW    = SUM_W - 1;
  localparam int SQ_W  = 2 * SUM_W;
  localparam int SHIFT = 32 - ANGLE_BITS;
  localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic [31:0] RND      = 32'd1 << (31 - ANGLE_BITS);
  localparam logic [CNT_W-1:0] BOUND = CNT_W'(MAX_SAMPLES);

  function automatic logic signed [15:0] q15_clamp(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + CW'(16384)) >>> 15;
    if (r > CW'(32767)) begin
      r = CW'(32767);
    end else if (r < -CW'(32767)) begin
      r = -CW'(32767);
    end
    return r[15:0];
  endfunction

  logic [15:0] phi_r, theta_r, psi_r;
  logic        last_r;
  logic [CNT_W-1:0] cnt_r;
  logic        ovf_r;
  logic signed [SUM_W-1:0] sx_r, sy_r, sz_r, sc_r, ss_r;
  logic signed [15:0] sp_r, cp_r, st_r, ct_r, sr_r, cr_r;
  logic signed [31:0] px_r, py_r;
  logic [SQ_W-1:0] sqa_r, sqb_r;
  logic [1:0]  sel_r, quad_r;
  logic        vec_r, zero_r;
  logic [15:0] ang_phi_r, ang_theta_r, ang_psi_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [1:0]  out_user_r;

  logic [15:0] rot_angle;
  logic [31:0] phase;
  logic signed [VW-1:0] xv, yv;
  logic signed [CW-1:0] xs, ys, cx0, cy0, cx, cy;
  logic [32:0] cz0;
  logic [31:0] cz, ang32;
  logic        c_start, c_busy, c_done, s_busy, vzero;
  logic [SUM_W-1:0] root;
  logic signed [15:0] cs_q, sn_q, rs, rc;
  logic signed [31:0] rpx, rpy;
  logic [AW-1:0] ax, ay;
  logic degen;
  logic [31:0] cnt32;

  always_comb begin
    case (cmd.sel)
      SEL_PHI:   rot_angle = phi_r;
      SEL_THETA: rot_angle = theta_r;
      default:   rot_angle = psi_r;
    endcase
    phase = (32'(rot_angle) & ANG_MASK) << SHIFT;

    case (cmd.sel)
      SEL_PHI: begin
        yv = VW'(sy_r);
        xv = VW'(sx_r);
      end
      SEL_THETA: begin
        yv = $signed({1'b0, root});
        xv = VW'(sz_r);
      end
      default: begin
        yv = VW'(ss_r);
        xv = VW'(sc_r);
      end
    endcase
    vzero = (xv == '0) && (yv == '0);
    xs    = CW'(xv) <<< 12;
    ys    = CW'(yv) <<< 12;

    if (cmd.vec_start) begin
      if (xv < 0) begin
        cx0 = -xs;
        cy0 = -ys;
        cz0 = 33'h080000000;
      end else begin
        cx0 = xs;
        cy0 = ys;
        cz0 = '0;
      end
    end else begin
      cx0 = CW'(CORDIC_GAIN_INV);
      cy0 = '0;
      cz0 = {3'b000, phase[29:0]};
    end
  end

  assign c_start = cmd.rot_start | cmd.vec_start;

  eacm_cordic #(.CW(CW)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (c_start),
    .vec_mode (cmd.vec_start),
    .x0       (cx0),
    .y0       (cy0),
    .z0       (cz0),
    .busy     (c_busy),
    .done     (c_done),
    .x        (cx),
    .y        (cy),
    .z        (cz)
  );

  eacm_isqrt #(.W(SUM_W)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (sqa_r + sqb_r),
    .busy     (s_busy),
    .root     (root)
  );

  always_comb begin
    cs_q = q15_clamp(cx);
    sn_q = q15_clamp(cy);
    case (quad_r)
      2'd0: begin
        rc = cs_q;
        rs = sn_q;
      end
      2'd1: begin
        rc = -sn_q;
        rs = cs_q;
      end
      2'd2: begin
        rc = -cs_q;
        rs = -sn_q;
      end
      default: begin
        rc = sn_q;
        rs = -cs_q;
      end
    endcase
    ang32 = zero_r ? 32'd0 : ((cz + RND) >> SHIFT);
    rpx   = (px_r + 32'sd16384) >>> 15;
    rpy   = (py_r + 32'sd16384) >>> 15;
    ax    = sx_r[SUM_W-1] ? AW'(-sx_r) : AW'(sx_r);
    ay    = sy_r[SUM_W-1] ? AW'(-sy_r) : AW'(sy_r);
    degen = (sx_r == '0) && (sy_r == '0) && (sz_r == '0);
    cnt32 = 32'(cnt_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      phi_r   <= in_phi;
      theta_r <= in_theta;
      psi_r   <= in_psi;
      last_r  <= in_last;
    end
    if (c_start) begin
      sel_r  <= cmd.sel;
      vec_r  <= cmd.vec_start;
      zero_r <= vzero;
      quad_r <= phase[31:30];
    end
    if (c_done && !vec_r) begin
      case (sel_r)
        SEL_PHI: begin
          sp_r <= rs;
          cp_r <= rc;
        end
        SEL_THETA: begin
          st_r <= rs;
          ct_r <= rc;
        end
        default: begin
          sr_r <= rs;
          cr_r <= rc;
        end
      endcase
    end
    if (c_done && vec_r) begin
      case (sel_r)
        SEL_PHI:   ang_phi_r   <= ang32[15:0];
        SEL_THETA: ang_theta_r <= ang32[15:0];
        default:   ang_psi_r   <= ang32[15:0];
      endcase
    end
    if (cmd.mul) begin
      px_r <= st_r * cp_r;
      py_r <= st_r * sp_r;
    end
    if (cmd.sq) begin
      sqa_r <= SQ_W'(ax) * SQ_W'(ax);
      sqb_r <= SQ_W'(ay) * SQ_W'(ay);
    end
    if (cmd.out_load) begin
      out_data_r <= {3'b000, cnt32[12:0], ang_psi_r,
                     degen ? 16'd0 : ang_theta_r, degen ? 16'd0 : ang_phi_r};
      out_user_r <= {ovf_r, degen};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r        <= '0;
      sy_r        <= '0;
      sz_r        <= '0;
      sc_r        <= '0;
      ss_r        <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        sx_r        <= '0;
        sy_r        <= '0;
        sz_r        <= '0;
        sc_r        <= '0;
        ss_r        <= '0;
        cnt_r       <= '0;
        ovf_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        if (out_tready) begin
          out_valid_r <= 1'b0;
        end
        if (cmd.drop) begin
          ovf_r <= 1'b1;
        end
        if (cmd.accum) begin
          sx_r  <= sx_r + SUM_W'(rpx);
          sy_r  <= sy_r + SUM_W'(rpy);
          sz_r  <= sz_r + SUM_W'(ct_r);
          sc_r  <= sc_r + SUM_W'(cr_r);
          ss_r  <= ss_r + SUM_W'(sr_r);
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    sts.at_bound    = (cnt_r == BOUND);
    sts.last        = last_r;
    sts.cordic_busy = c_busy;
    sts.sqrt_busy   = s_busy;
    sts.out_busy    = out_valid_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

/* design/eacm_ctrl.sv */
// Controller state machine: sequences sample intake, the three sine/cosine
// rotations, accumulation and the final arctangent and square root passes.
// Depends on eacm_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module eacm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire eacm_pkg::eacm_sts_t sts,
  output eacm_pkg::eacm_cmd_t      cmd
);
  import eacm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ROT_PHI, S_ROT_THETA, S_ROT_PSI, S_MUL, S_ACC,
    S_SQ, S_VEC_GO, S_VEC_PHI, S_VEC_THETA, S_VEC_PSI, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.at_bound) begin
          cmd.drop  = 1'b1;
          state_nxt = sts.last ? S_SQ : S_IDLE;
        end else begin
          cmd.rot_start = 1'b1;
          cmd.sel       = SEL_PHI;
          state_nxt     = S_ROT_PHI;
        end
      end
      S_ROT_PHI: begin
        if (!sts.cordic_busy) begin
          cmd.rot_start = 1'b1;
          cmd.sel       = SEL_THETA;
          state_nxt     = S_ROT_THETA;
        end
      end
      S_ROT_THETA: begin
        if (!sts.cordic_busy) begin
          cmd.rot_start = 1'b1;
          cmd.sel       = SEL_PSI;
          state_nxt     = S_ROT_PSI;
        end
      end
      S_ROT_PSI: begin
        if (!sts.cordic_busy) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = sts.last ? S_SQ : S_IDLE;
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_VEC_GO;
      end
      S_VEC_GO: begin
        cmd.vec_start  = 1'b1;
        cmd.sqrt_start = 1'b1;
        cmd.sel        = SEL_PHI;
        state_nxt      = S_VEC_PHI;
      end
      S_VEC_PHI: begin
        if (!sts.cordic_busy && !sts.sqrt_busy) begin
          cmd.vec_start = 1'b1;
          cmd.sel       = SEL_THETA;
          state_nxt     = S_VEC_THETA;
        end
      end
      S_VEC_THETA: begin
        if (!sts.cordic_busy) begin
          cmd.vec_start = 1'b1;
          cmd.sel       = SEL_PSI;
          state_nxt     = S_VEC_PSI;
        end
      end
      S_VEC_PSI: begin
        if (!sts.cordic_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over a pending beat");
  a_cordic_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rot_start || cmd.vec_start) |-> !sts.cordic_busy)
    else $error("CORDIC started while busy");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!sts.cordic_busy && !sts.sqrt_busy))
    else $error("input taken while a unit is still running");
`endif

endmodule

`default_nettype wire

/* design/euler_attitude_circular_mean_unit.sv */
// Circular mean of a run of attitude samples (Euler angles as binary angles).
// Input beat: one sample; tlast marks the end of a run and yields one result beat.
// Each accepted sample within MAX_SAMPLES runs three 24-step rotations of the
// shared CORDIC, plus intake, check, multiply and accumulate, before the next beat
// is accepted. in_tready is high only while the unit waits for a sample. The last
// sample of a run then adds three vectoring passes of the same CORDIC, the second
// waiting on the square root that runs beside the first (29 steps at the default
// parameters), before the result is loaded into the output register.
// The output register holds one result beat; while it waits for out_tready
// the next run's samples are still taken, and only the next result waits.
// Reset (synchronous, active low) clears the sums, the sample count, the
// overflow flag and the output valid; no result is pending after reset.
// Samples beyond MAX_SAMPLES in a run are dropped and flag the overflow.
// Depends on eacm_pkg, eacm_ctrl and eacm_datapath.
`timescale 1ns / 1ps
`default_nettype none

module euler_attitude_circular_mean_unit #(
  parameter int MAX_SAMPLES = eacm_pkg::MAX_SAMPLES_DEF,
  parameter int ANGLE_BITS  = eacm_pkg::ANGLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // phi_angle [15:0], theta_angle [31:16], psi_angle [47:32]
  input  wire logic [47:0] in_tdata,
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // mean_phi [15:0], mean_theta [31:16], mean_psi [47:32], sample_count [60:48]
  output logic [63:0]      out_tdata,
  // degenerate [0], count_overflow [1]
  output logic [1:0]       out_tuser
);
  import eacm_pkg::*;

  eacm_cmd_t cmd;
  eacm_sts_t sts;

  eacm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  eacm_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .ANGLE_BITS  (ANGLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_phi     (in_tdata[15:0]),
    .in_theta   (in_tdata[31:16]),
    .in_psi     (in_tdata[47:32]),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

/* tb/sv/eacm_checker.sv */
// Checker for the attitude circular mean unit: follows both stream channels,
// predicts every result beat from the accepted samples and compares field by field.
// Depends on nothing but the channel signals handed in by tb_top.
`timescale 1ns / 1ps

module eacm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          errors,
  output int          pending
);

  localparam int MAX_RUN = 4096;
  localparam int STEPS = 24;
  localparam longint GAIN_INV = 64'd652032874;

  typedef struct packed {
    logic [15:0] phi;
    logic [15:0] theta;
    logic [15:0] psi;
    logic [12:0] count;
    logic        degen;
    logic        ovf;
  } mean_t;

  mean_t expected_means[$];
  longint acc_x, acc_y, acc_z, acc_rc, acc_rs;
  int     run_len;
  logic   run_ovf;

  function automatic logic [31:0] turn_atan(input int i);
    logic [31:0] t [STEPS];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
          32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
          32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
          32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return t[i];
  endfunction

  function automatic longint round_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32767) r = -32767;
    return r;
  endfunction

  task automatic sine_cosine(input logic [15:0] ang, output longint sn, output longint cs);
    logic [31:0] ph;
    longint x, y, z, xo, c0, s0;
    ph = {ang, 16'h0};
    z = longint'(ph[29:0]);
    x = GAIN_INV;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      xo = x;
      if (z >= 0) begin
        x -= y >>> i; y += xo >>> i; z -= longint'(turn_atan(i));
      end else begin
        x += y >>> i; y -= xo >>> i; z += longint'(turn_atan(i));
      end
    end
    c0 = round_q15(x);
    s0 = round_q15(y);
    case (ph[31:30])
      2'd0: begin cs = c0;  sn = s0;  end
      2'd1: begin cs = -s0; sn = c0;  end
      2'd2: begin cs = -c0; sn = -s0; end
      default: begin cs = s0; sn = -c0; end
    endcase
  endtask

  function automatic longint mul_q15(input longint a, input longint b);
    return (a * b + 16384) >>> 15;
  endfunction

  function automatic logic [15:0] arc_angle(input longint y, input longint x);
    logic [31:0] z;
    logic [31:0] r;
    longint xo;
    z = 0;
    if (x == 0 && y == 0) return 16'h0;
    x = x * 4096;
    y = y * 4096;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < STEPS; i++) begin
      xo = x;
      if (y > 0) begin
        x += y >>> i; y -= xo >>> i; z += turn_atan(i);
      end else begin
        x -= y >>> i; y += xo >>> i; z -= turn_atan(i);
      end
    end
    r = z + 32'h8000;
    return r[31:16];
  endfunction

  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  task automatic accumulate_sample(input logic [47:0] d, input logic last);
    longint sp, cp, st, ct, ss, cs, ax, ay;
    mean_t m;
    if (run_len >= MAX_RUN) begin
      run_ovf = 1'b1;
    end else begin
      sine_cosine(d[15:0], sp, cp);
      sine_cosine(d[31:16], st, ct);
      sine_cosine(d[47:32], ss, cs);
      acc_x += mul_q15(st, cp);
      acc_y += mul_q15(st, sp);
      acc_z += ct;
      acc_rc += cs;
      acc_rs += ss;
      run_len++;
    end
    if (last) begin
      m = '0;
      if (acc_x == 0 && acc_y == 0 && acc_z == 0) begin
        m.degen = 1'b1;
      end else begin
        ax = (acc_x < 0) ? -acc_x : acc_x;
        ay = (acc_y < 0) ? -acc_y : acc_y;
        m.phi = arc_angle(acc_y, acc_x);
        m.theta = arc_angle(floor_sqrt(ax * ax + ay * ay), acc_z);
      end
      m.psi = arc_angle(acc_rs, acc_rc);
      m.count = run_len[12:0];
      m.ovf = run_ovf;
      expected_means.push_back(m);
      acc_x = 0; acc_y = 0; acc_z = 0; acc_rc = 0; acc_rs = 0;
      run_len = 0;
      run_ovf = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    acc_x = 0; acc_y = 0; acc_z = 0; acc_rc = 0; acc_rs = 0;
    run_len = 0;
    run_ovf = 1'b0;
  end

  assign pending = expected_means.size();

  always @(posedge clk) begin
    mean_t m;
    if (rst_n) begin
      if (in_tvalid && in_tready) accumulate_sample(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_means.size() == 0) begin
          $display("%0t unexpected result beat", $realtime);
          errors++;
        end else begin
          m = expected_means.pop_front();
          if (out_tdata[15:0] !== m.phi) report_mismatch("mean_phi", out_tdata[15:0], m.phi);
          if (out_tdata[31:16] !== m.theta)
            report_mismatch("mean_theta", out_tdata[31:16], m.theta);
          if (out_tdata[47:32] !== m.psi) report_mismatch("mean_psi", out_tdata[47:32], m.psi);
          if (out_tdata[60:48] !== m.count)
            report_mismatch("sample_count", out_tdata[60:48], m.count);
          if (out_tuser[0] !== m.degen) report_mismatch("degenerate", out_tuser[0], m.degen);
          if (out_tuser[1] !== m.ovf) report_mismatch("count_overflow", out_tuser[1], m.ovf);
        end
      end
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Top of the testbench for euler_attitude_circular_mean_unit: clock, reset,
// sample stimulus with bursts and gaps, output stalls and the verdict.
// Depends on eacm_checker and the unit under test.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          burst_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  euler_attitude_circular_mean_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  eacm_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** euler_attitude_circular_mean_unit: FAILED **");
      $finish;
    end
  end

  // The receiver alternates between always ready, a coin toss and long stalls.
  always @(posedge clk) begin
    case ((cycles / 1500) % 3)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(1, 0));
      default: out_tready <= ($urandom_range(7, 0) == 0);
    endcase
  end

  task automatic send_sample(input logic [15:0] phi, input logic [15:0] theta,
                             input logic [15:0] psi, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(4) == 0 ? 0 : $urandom_range(120, 1);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(12, 1);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {psi, theta, phi};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_random_run(input int len);
    logic [15:0] th;
    for (int i = 0; i < len; i++) begin
      th = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(32768, 0));
      send_sample(16'($urandom), th, 16'($urandom), i == len - 1);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    int sent;
    int len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_sample(16'hFFFF, 16'h8000, 16'hFFFF, 1'b1);
    send_sample(16'h5555, 16'h2AAA, 16'hAAAA, 1'b0);
    send_sample(16'hAAAA, 16'h5555, 16'h5555, 1'b1);
    // Opposite equatorial directions cancel: the pointing sum is zero.
    send_sample(16'h0000, 16'h4000, 16'h1234, 1'b0);
    send_sample(16'h8000, 16'h4000, 16'h1234, 1'b1);
    // Both poles cancel along z, and the roll sums cancel too.
    send_sample(16'h3000, 16'h0000, 16'h0000, 1'b0);
    send_sample(16'h3000, 16'h8000, 16'h8000, 1'b1);
    // Pointing straight up and straight down.
    send_sample(16'h7000, 16'h0000, 16'h4000, 1'b1);
    send_sample(16'h7000, 16'h8000, 16'hC000, 1'b1);
    // Theta beyond half a turn is taken as given.
    send_sample(16'h1000, 16'h9C40, 16'h2000, 1'b0);
    send_sample(16'hF000, 16'hFFFF, 16'h0001, 1'b1);
    send_sample(16'h4000, 16'h4000, 16'hC000, 1'b0);
    send_sample(16'hC000, 16'h2000, 16'h8001, 1'b0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    drain_results();

    sent = 0;
    while (sent < 850) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 1);
      send_random_run(len);
      sent += len;
      if (sent > 400 && sent - len <= 400) drain_results();
    end

    drain_results();
    if (errors == 0 && pending == 0) begin
      $display("** euler_attitude_circular_mean_unit: PASSED **");
    end else begin
      $display("** euler_attitude_circular_mean_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* euler_attitude_circular_mean_unit.f */
design/eacm_pkg.sv
design/eacm_cordic.sv
design/eacm_isqrt.sv
design/eacm_datapath.sv
design/eacm_ctrl.sv
design/euler_attitude_circular_mean_unit.sv
tb/sv/eacm_checker.sv
tb/sv/tb_top.sv
